// File: rtl/gfpd_pkg.sv
package gfpd_pkg;

   // Largest divisor degree the window supports.
   localparam int MAX_TAPS = 32;
   // Longest message; the position counter never reaches this value.
   localparam int MAX_LENGTH = 255;

   localparam int COEF_W      = 8;
   localparam int TAP_COUNT_W = $clog2(MAX_TAPS + 1);
   localparam int MSG_LEN_W   = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int TAP_WORDS   = (MAX_TAPS * COEF_W) / CSR_DATA_W;

   // Field polynomial x^8+x^4+x^3+x^2+1 with the x^8 term dropped.
   localparam logic [COEF_W-1:0] GF_POLY_LOW = 8'h1D;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_LOW      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_MID_LOW  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_MID_HIGH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_HIGH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MSG_LENGTH    = 3'd5;

   typedef logic [MAX_TAPS-1:0][COEF_W-1:0] coef_vec_type;

   // Controls for one update of the pending window.
   typedef struct packed {
      logic                   feed;       // quotient word: add value times taps
      logic                   clear;      // last word of the message
      logic [TAP_COUNT_W-1:0] tap_count;  // saturated number of live taps
   } window_ctrl_type;

   // GF(2^8) product, one shift-and-reduce step per multiplier bit.
   function automatic logic [COEF_W-1:0] gf_mul(input logic [COEF_W-1:0] a,
                                                input logic [COEF_W-1:0] b);
      logic [COEF_W-1:0] x;
      logic [COEF_W-1:0] acc;
      x   = a;
      acc = '0;
      for (int i = 0; i < COEF_W; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = x[COEF_W-1] ? ({x[COEF_W-2:0], 1'b0} ^ GF_POLY_LOW) : {x[COEF_W-2:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

// File: rtl/gfpd_feedback.sv
// Next value of the pending window: shift by one place towards the oldest
// entry, add the fed-back products on the live taps, clear at message end.
module gfpd_feedback import gfpd_pkg::*; (
   input  coef_vec_type      window,
   input  coef_vec_type      taps,
   input  logic [COEF_W-1:0] value,
   input  window_ctrl_type   ctrl,
   output coef_vec_type      window_next
);

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
      localparam logic [TAP_COUNT_W-1:0] TapIdx = TAP_COUNT_W'(k);
      logic [COEF_W-1:0] shifted;
      logic [COEF_W-1:0] product;

      if (k == MAX_TAPS - 1) begin : g_top
         assign shifted = '0;
      end else begin : g_mid
         assign shifted = window[k+1];
      end

      assign product = gf_mul(taps[k], value);

      always_comb begin
         if (ctrl.clear) begin
            window_next[k] = '0;
         end else if (ctrl.feed && (TapIdx < ctrl.tap_count)) begin
            window_next[k] = shifted ^ product;
         end else begin
            window_next[k] = shifted;
         end
      end
   end

endmodule

// File: rtl/gf256_polynomial_divide_unit.sv
// Streaming synthetic division over GF(2^8), field polynomial 0x11D, as used
// to form Reed-Solomon parity. The divisor is monic; its leading 1 is implied.
//
// Input channel (req_): one dividend coefficient per word, highest degree
// first. Result channel (rsp_): one word per input word, carrying the
// quotient or remainder coefficient, a remainder flag and a last flag on the
// final word of each message. Configuration (csr_): taps, tap count and
// message length, to be written by the user only while the block is idle;
// the block itself does not enforce this. csr_ready is always high.
//
// An accepted word is held in the input register, worked through the window
// update once the result register is free, and sits in the result register
// until the receiver takes it. One word is accepted every cycle unless the
// receiver stalls; the rate is set by the combinational update of all 32
// pending sums, each through its own GF(2^8) multiplier.
//
// While the receiver stalls, the result register holds its word; once the
// input register is also full, req_stall rises. Reset empties both registers,
// clears the window and position and restores the register defaults (tap
// count 32, message length 255, taps zero). No clearing pass is needed.
module gf256_polynomial_divide_unit import gfpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COEF_W-1:0]      req_dividend_coef,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COEF_W-1:0]      rsp_result_coef,
   output logic                   rsp_is_remainder,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   logic [TAP_WORDS-1:0][CSR_DATA_W-1:0] taps_ff, taps_in;
   logic [TAP_COUNT_W-1:0]               tap_count_ff, tap_count_in;
   logic [MSG_LEN_W-1:0]                 msg_len_ff, msg_len_in;

   // Input stage and result stage.
   logic              in_valid_ff, in_valid_in;
   logic [COEF_W-1:0] in_coef_ff, in_coef_in;
   logic              out_valid_ff, out_valid_in;
   logic [COEF_W-1:0] out_coef_ff, out_coef_in;
   logic              out_rem_ff, out_rem_in;
   logic              out_last_ff, out_last_in;

   // Division state.
   coef_vec_type         window_ff, window_in;
   logic [MSG_LEN_W-1:0] pos_ff, pos_in;

   coef_vec_type           tap_bytes;
   logic [TAP_COUNT_W-1:0] tc_sat;
   logic [MSG_LEN_W-1:0]   quot_len;
   logic [COEF_W-1:0]      value;
   logic                   in_quotient;
   logic                   is_last;
   logic                   advance;
   logic                   accept;
   window_ctrl_type        wctrl;
   coef_vec_type           window_next;

   // Handshakes. The input stage moves on whenever the result register is
   // empty or its word is being taken.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Tap k sits in byte k of the packed registers, low word and byte first.
   assign tap_bytes = taps_ff;

   assign tc_sat   = (tap_count_ff > TAP_COUNT_W'(MAX_TAPS)) ?
                     TAP_COUNT_W'(MAX_TAPS) : tap_count_ff;
   assign quot_len = (msg_len_ff > MSG_LEN_W'(tc_sat)) ?
                     (msg_len_ff - MSG_LEN_W'(tc_sat)) : '0;

   assign value       = in_coef_ff ^ window_ff[0];
   assign in_quotient = pos_ff < quot_len;
   assign is_last     = (msg_len_ff <= MSG_LEN_W'(1)) ||
                        (pos_ff >= (msg_len_ff - MSG_LEN_W'(1)));

   assign wctrl.feed      = in_quotient;
   assign wctrl.clear     = is_last;
   assign wctrl.tap_count = tc_sat;

   gfpd_feedback u_feedback (
      .window      (window_ff),
      .taps        (tap_bytes),
      .value       (value),
      .ctrl        (wctrl),
      .window_next (window_next)
   );

   // Configuration decode.
   always_comb begin
      taps_in      = taps_ff;
      tap_count_in = tap_count_ff;
      msg_len_in   = msg_len_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TAPS_LOW:      taps_in[0]   = csr_data;
            CSR_TAPS_MID_LOW:  taps_in[1]   = csr_data;
            CSR_TAPS_MID_HIGH: taps_in[2]   = csr_data;
            CSR_TAPS_HIGH:     taps_in[3]   = csr_data;
            CSR_TAP_COUNT:     tap_count_in = csr_data[TAP_COUNT_W-1:0];
            CSR_MSG_LENGTH:    msg_len_in   = csr_data[MSG_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline and state update.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_coef_in   = in_coef_ff;
      out_valid_in = out_valid_ff;
      out_coef_in  = out_coef_ff;
      out_rem_in   = out_rem_ff;
      out_last_in  = out_last_ff;
      window_in    = window_ff;
      pos_in       = pos_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_coef_in  = value;
         out_rem_in   = !in_quotient;
         out_last_in  = is_last;
         window_in    = window_next;
         pos_in       = is_last ? '0 : (pos_ff + MSG_LEN_W'(1));
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_coef_in  = req_dividend_coef;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff      <= '0;
         tap_count_ff <= TAP_COUNT_W'(MAX_TAPS);
         msg_len_ff   <= MSG_LEN_W'(MAX_LENGTH);
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
         pos_ff       <= '0;
      end else begin
         taps_ff      <= taps_in;
         tap_count_ff <= tap_count_in;
         msg_len_ff   <= msg_len_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         window_ff    <= window_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      in_coef_ff  <= in_coef_in;
      out_coef_ff <= out_coef_in;
      out_rem_ff  <= out_rem_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_coef  = out_coef_ff;
   assign rsp_is_remainder = out_rem_ff;
   assign rsp_last         = out_last_ff;

   // The position stays below the longest message length.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != MSG_LEN_W'(MAX_LENGTH))
      else $error("position counter out of range");

   // The last word of a message leaves a clean window and position.
   a_msg_end_clear: assert property (@(posedge clock) disable iff (reset)
      advance && is_last |=> (pos_ff == '0) && (window_ff == '0))
      else $error("window not cleared after last word");

   // Within a message the position advances by exactly one per word.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      advance && !is_last |=> pos_ff == ($past(pos_ff) + MSG_LEN_W'(1)))
      else $error("position did not step");

   // The input is held off only when both stages are full and blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("stall without a full pipeline");

endmodule

// File: tb/tb_top.sv
module tb_top;
   import gfpd_pkg::*;

   // Indexes with no register behind them. Writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_B = 3'd7;

   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_TARGET  = 40;     // rough number of words per random phase
   localparam int DRAIN_CYCLES  = 6;      // margin after the last result word
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SHOWN_LIMIT   = 10;

   // One result word as the block should present it.
   typedef struct packed {
      logic [COEF_W-1:0] coef;
      logic              is_rem;
      logic              last;
   } div_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [COEF_W-1:0]      req_dividend_coef = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COEF_W-1:0]      rsp_result_coef;
   logic                   rsp_is_remainder;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Our own view of the divider: tap registers, live tap count, message
   // length, the window of pending sums (entry 0 is the oldest) and the
   // position within the current message.
   logic [CSR_DATA_W-1:0]  tap_words [TAP_WORDS];
   logic [TAP_COUNT_W-1:0] live_taps;
   logic [MSG_LEN_W-1:0]   msg_len_reg;
   logic [COEF_W-1:0]      win_sums [MAX_TAPS];
   int                     msg_pos;

   // Dividend coefficients still to be offered, and the result words owed
   // by the block for coefficients it has already taken.
   logic [COEF_W-1:0]      dividend_queue [$];
   div_word_type           predicted_words [$];

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int pause_at       = -1;
   int words_accepted = 0;
   int messages_seen  = 0;
   int remainder_seen = 0;
   int settings_used  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   gf256_polynomial_divide_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dividend_coef (req_dividend_coef),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_coef   (rsp_result_coef),
      .rsp_is_remainder  (rsp_is_remainder),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // GF(2^8) product by Horner's rule: walk the bits of a from the top,
   // doubling the running sum in the field and adding b where the bit is set.
   function automatic logic [COEF_W-1:0] gf_product(input logic [COEF_W-1:0] a,
                                                    input logic [COEF_W-1:0] b);
      logic [COEF_W-1:0] sum;
      sum = '0;
      for (int i = COEF_W - 1; i >= 0; i--) begin
         sum = {sum[COEF_W-2:0], 1'b0} ^ (sum[COEF_W-1] ? GF_POLY_LOW : '0);
         if (a[i]) begin
            sum = sum ^ b;
         end
      end
      return sum;
   endfunction

   // Takes one dividend coefficient, advances the window and the position,
   // and returns the word the block should produce for it.
   function automatic div_word_type divide_step(input logic [COEF_W-1:0] coef);
      int                tc;
      int                len;
      int                qlen;
      logic [COEF_W-1:0] v;
      logic              in_quot;
      div_word_type      w;
      tc      = (live_taps > MAX_TAPS) ? MAX_TAPS : live_taps;
      len     = msg_len_reg;
      qlen    = (len > tc) ? len - tc : 0;
      v       = coef ^ win_sums[0];
      in_quot = (msg_pos < qlen);
      w.coef   = v;
      w.is_rem = !in_quot;
      w.last   = (len <= 1) || (msg_pos >= len - 1);
      for (int k = 0; k < MAX_TAPS - 1; k++) begin
         win_sums[k] = win_sums[k+1];
      end
      win_sums[MAX_TAPS-1] = '0;
      // Tap k is byte k of the packed tap registers, low byte first.
      if (in_quot && v != '0) begin
         for (int k = 0; k < tc; k++) begin
            win_sums[k] = win_sums[k] ^ gf_product(tap_words[k / 8][(k % 8) * 8 +: 8], v);
         end
      end
      if (w.last) begin
         foreach (win_sums[k]) win_sums[k] = '0;
         msg_pos = 0;
      end else begin
         msg_pos = (msg_pos + 1) & 255;
      end
      return w;
   endfunction

   // One register write. The valid is left high; the caller lowers it once
   // the whole batch has gone, so that it is never dropped and raised again
   // within one time step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TAPS_LOW:      tap_words[0] = data;
         CSR_TAPS_MID_LOW:  tap_words[1] = data;
         CSR_TAPS_MID_HIGH: tap_words[2] = data;
         CSR_TAPS_HIGH:     tap_words[3] = data;
         CSR_TAP_COUNT:     live_taps    = data[TAP_COUNT_W-1:0];
         CSR_MSG_LENGTH:    msg_len_reg  = data[MSG_LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Writes every register. The count and the length travel with random
   // upper bits, which the block is expected to ignore.
   task automatic configure(input logic [CSR_DATA_W-1:0] t0, input logic [CSR_DATA_W-1:0] t1,
                            input logic [CSR_DATA_W-1:0] t2, input logic [CSR_DATA_W-1:0] t3,
                            input int tc, input int len, input bit with_spares);
      logic [CSR_DATA_W-1:0] data;
      write_reg(CSR_TAPS_LOW, t0);
      write_reg(CSR_TAPS_MID_LOW, t1);
      write_reg(CSR_TAPS_MID_HIGH, t2);
      write_reg(CSR_TAPS_HIGH, t3);
      data = {$urandom, $urandom};
      data[TAP_COUNT_W-1:0] = tc[TAP_COUNT_W-1:0];
      write_reg(CSR_TAP_COUNT, data);
      data = {$urandom, $urandom};
      data[MSG_LEN_W-1:0] = len[MSG_LEN_W-1:0];
      write_reg(CSR_MSG_LENGTH, data);
      if (with_spares) begin
         write_reg(CSR_UNMAPPED_A, {$urandom, $urandom});
         write_reg(CSR_UNMAPPED_B, {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Four traffic patterns: free flowing, a sparse sender, a slow receiver,
   // and light gaps on both sides.
   task automatic set_mode(input int m);
      case (m % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 74; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 74; end
         default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
   endtask

   // Blocks until every coefficient has been taken and every result word
   // has come back, so that registers may be written safely. The state is
   // sampled between edges, where the sender and receiver have settled,
   // and the task returns on the following rising edge.
   task automatic settle();
      while (dividend_queue.size() != 0 || req_valid || predicted_words.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= SHOWN_LIMIT) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Sender. A word that is held off by req_stall stays exactly as it is;
   // otherwise the next coefficient is offered unless this cycle is idle or
   // the pressure hold-off is in force. Each accepted coefficient is run
   // through the predictor at the edge where it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_words.insert(predicted_words.size(), divide_step(req_dividend_coef));
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (dividend_queue.size() != 0 &&
                !(words_accepted == pause_at && predicted_words.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid         <= 1'b1;
               req_dividend_coef <= dividend_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Stall is drawn afresh each cycle; a word counts as taken at
   // an edge where rsp_valid is high and our stall was low.
   always @(posedge clock) begin
      div_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
               note_mismatch($sformatf("unexpected word coef=%02h rem=%0b last=%0b",
                                       rsp_result_coef, rsp_is_remainder, rsp_last));
            end else begin
               want = predicted_words.pop_front();
               if (rsp_result_coef !== want.coef || rsp_is_remainder !== want.is_rem ||
                   rsp_last !== want.last) begin
                  note_mismatch($sformatf(
                     "expected coef=%02h rem=%0b last=%0b, got coef=%02h rem=%0b last=%0b",
                     want.coef, want.is_rem, want.last,
                     rsp_result_coef, rsp_is_remainder, rsp_last));
               end
               if (want.last) messages_seen++;
               if (want.is_rem) remainder_seen++;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles, %0d result words still owed.",
                  cycle_count, predicted_words.size());
         $display("gf256_polynomial_divide_unit: mismatch");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] tw [TAP_WORDS];
      logic [CSR_DATA_W-1:0] dir_taps;
      int                    tc;
      int                    len;
      int                    eff_len;
      int                    n;
      logic [COEF_W-1:0]     coef;

      // The predictor starts from the register defaults that reset restores.
      foreach (tap_words[i]) tap_words[i] = '0;
      foreach (win_sums[i]) win_sums[i] = '0;
      live_taps   = TAP_COUNT_W'(MAX_TAPS);
      msg_len_reg = MSG_LEN_W'(MAX_LENGTH);
      msg_pos     = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A short divisor with extreme tap bytes over a full
      // eight-word message: quotient words feed back, remainder words only
      // shift the window.
      dir_taps = 64'h8040_2010_0804_02FF;
      set_mode(0);
      configure(dir_taps, '1, '0, 64'h0123_4567_89AB_CDEF, 4, 8, 1'b0);
      dividend_queue = {8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'hFF, 8'h00};
      settle();

      // With no taps the divider passes every coefficient through as quotient.
      set_mode(3);
      configure(dir_taps, '1, '0, '1, 0, 3, 1'b0);
      dividend_queue = {8'hFF, 8'h7F, 8'h01};
      settle();

      // A length of one makes each coefficient its own message; with no taps
      // it is a quotient word.
      set_mode(1);
      configure(dir_taps, '1, '0, '1, 0, 1, 1'b0);
      dividend_queue = {8'hFF, 8'h80};
      settle();

      // A length of zero behaves the same way; here the full divisor leaves
      // no quotient region at all.
      set_mode(2);
      configure('1, '1, '1, '1, MAX_TAPS, 0, 1'b0);
      dividend_queue = {8'h01, 8'hFE};
      settle();

      // A tap count above the window depth saturates, and a divisor no
      // shorter than the message makes every word part of the remainder.
      set_mode(3);
      configure('1, '0, '1, '0, 63, 5, 1'b0);
      dividend_queue = {8'h12, 8'hFF, 8'h00, 8'h80, 8'h01};
      settle();

      // Shortening the message after three words: the next word is already
      // past the new final position, so it closes the message at once.
      set_mode(0);
      configure(64'h0000_0000_0000_1D8E, '0, '0, '0, 2, 8, 1'b0);
      dividend_queue = {8'hC3, 8'h3C, 8'h99};
      settle();
      configure(64'h0000_0000_0000_1D8E, '0, '0, '0, 2, 2, 1'b0);
      dividend_queue = {8'hE7, 8'h18};
      settle();

      // Random part. Mostly whole messages with random content; now and then
      // a phase stops part way, so the next setting lands mid-message.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < TAP_WORDS; i++) begin
            case ($urandom_range(5))
               0:       tw[i] = '0;
               1:       tw[i] = '1;
               default: tw[i] = {$urandom, $urandom};
            endcase
         end
         case ($urandom_range(9))
            0:       tc = 0;
            1:       tc = 1;
            2:       tc = MAX_TAPS;
            3:       tc = $urandom_range(MAX_TAPS + 1, 63);
            default: tc = $urandom_range(2, 16);
         endcase
         case ($urandom_range(9))
            0:       len = 2;
            1:       len = $urandom_range(1);
            2:       len = $urandom_range(25, 60);
            default: len = $urandom_range(3, 20);
         endcase
         // Two phases are pinned to the extremes: a one-tap divisor on a
         // two-word message, and the full divisor on the longest one.
         if (p == 0) begin
            tc  = 1;
            len = 2;
         end else if (p == 1) begin
            tc  = MAX_TAPS;
            len = MAX_LENGTH;
         end
         settle();
         set_mode(p);
         configure(tw[0], tw[1], tw[2], tw[3], tc, len, (p == 0));

         eff_len = (len <= 1) ? 1 : len;
         n = PHASE_TARGET / eff_len;
         if (n == 0) n = 1;
         n = n * eff_len;
         if (eff_len > 1 && $urandom_range(2) == 0) begin
            n = n + $urandom_range(1, eff_len - 1);
         end
         // Somewhere inside the phase the sender waits for every owed
         // result before going on.
         pause_at = (n > 1) ? words_accepted + $urandom_range(1, n - 1) : -1;
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(15))
               0, 1:    coef = '0;
               2:       coef = '1;
               default: coef = $urandom_range(255);
            endcase
            dividend_queue.insert(dividend_queue.size(), coef);
         end
      end

      settle();
      pause_at = -1;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Divided %0d coefficients into %0d messages (%0d remainder words) under %0d settings,",
               words_accepted, messages_seen, remainder_seen, settings_used);
      $display("with tap counts from none to saturated and lengths from zero to the maximum.");
      if (mismatch_count == 0) begin
         $display("gf256_polynomial_divide_unit: match");
      end else begin
         $display("%0d mismatching words in total.", mismatch_count);
         $display("gf256_polynomial_divide_unit: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/gfpd_pkg.sv
rtl/gfpd_feedback.sv
rtl/gf256_polynomial_divide_unit.sv
tb/tb_top.sv
